### src/fprs_pkg.sv
// fprs_pkg: shared types and constants for the framed packet receiver/scaler.
// No dependencies.
package fprs_pkg;

  localparam logic [7:0] HEADER_BYTE  = 8'hA5;
  localparam logic [7:0] TRAILER_BYTE = 8'h5A;
  localparam logic [31:0] CANON_NAN   = 32'h7FC0_0000;
  // single-precision constants 3.0 and 0.7 (0.7 rounded to nearest)
  localparam logic [31:0] K_THREE     = 32'h4040_0000;
  localparam logic [31:0] K_SEVENTENTH = 32'h3F33_3333;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DATA = 2'd1,
    PH_TAIL = 2'd2
  } rx_phase_t;

  // one complete frame handed from the front to the back
  typedef struct packed {
    logic [7:0]  mode;
    logic [31:0] f1;
    logic [31:0] f2;
  } frame_t;

  // multiplier pipeline stage 1 contents
  typedef struct packed {
    logic        sign;
    logic        is_nan;
    logic        is_inf;
    logic        is_zero;
    logic signed [10:0] exp;   // unbiased exponent sum of a and b
    logic [47:0] prod;         // mantissa product, msb at bit 47 or 46 when both operands are normal
  } mul_s1_t;

endpackage

### src/fprs_front.sv
// fprs_front: byte framing state machine; collects payload and emits frames.
// Depends on fprs_pkg.
module fprs_front #(
  parameter int PAYLOAD_BYTES = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  output logic                frame_valid,
  output fprs_pkg::frame_t    frame
);

  localparam int CW = $clog2(PAYLOAD_BYTES + 1);

  fprs_pkg::rx_phase_t rx_phase, rx_phase_next;
  logic [CW-1:0] byte_count;
  logic [7:0]    payload_store [PAYLOAD_BYTES];
  logic          store_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase   <= fprs_pkg::PH_IDLE;
      byte_count <= '0;
    end else if (in_valid) begin
      rx_phase <= rx_phase_next;
      if (rx_phase == fprs_pkg::PH_DATA) byte_count <= byte_count + 1'b1;
      else if (rx_phase_next == fprs_pkg::PH_DATA) byte_count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) payload_store[byte_count[$clog2(PAYLOAD_BYTES)-1:0]] <= in_byte;
  end

  always_comb begin
    rx_phase_next = rx_phase;
    store_en      = 1'b0;
    frame_valid   = 1'b0;
    unique case (rx_phase)
      fprs_pkg::PH_DATA: begin
        store_en = in_valid;
        if (byte_count == CW'(PAYLOAD_BYTES - 1)) rx_phase_next = fprs_pkg::PH_TAIL;
      end
      fprs_pkg::PH_TAIL: begin
        if (in_byte == fprs_pkg::TRAILER_BYTE) begin
          rx_phase_next = fprs_pkg::PH_IDLE;
          frame_valid   = in_valid;
        end
      end
      default: begin
        rx_phase_next = (in_byte == fprs_pkg::HEADER_BYTE) ? fprs_pkg::PH_DATA
                                                           : fprs_pkg::PH_IDLE;
      end
    endcase
  end

  assign frame.mode = payload_store[0];
  assign frame.f1   = {payload_store[4], payload_store[3], payload_store[2], payload_store[1]};
  assign frame.f2   = {payload_store[8], payload_store[7], payload_store[6], payload_store[5]};

endmodule

### src/fprs_fifo.sv
// fprs_fifo: small synchronous queue with registered storage.
// Depends on fprs_pkg.
module fprs_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  fprs_pkg::frame_t wr_data,
  output logic             full,
  input  logic             rd_en,
  output fprs_pkg::frame_t rd_data,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  fprs_pkg::frame_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en && !full) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en && !full) wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (rd_en && !empty) rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
    end
  end

endmodule

### src/fprs_fmul.sv
// fprs_fmul: two-stage IEEE single multiplier, round to nearest even,
// subnormals kept, NaN results canonical. Depends on fprs_pkg.
module fprs_fmul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  fprs_pkg::mul_s1_t s1, s1_next;

  logic [23:0] ma, mb;
  logic signed [10:0] ea, eb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

  // unpack: subnormals get exponent -126 with hidden bit 0
  always_comb begin
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    a_zero = (a[30:0] == '0);
    b_zero = (b[30:0] == '0);
    ma = {(a[30:23] != 8'h00), a[22:0]};
    mb = {(b[30:23] != 8'h00), b[22:0]};
    ea = (a[30:23] == 8'h00) ? -11'sd126 : $signed({3'b000, a[30:23]}) - 11'sd127;
    eb = (b[30:23] == 8'h00) ? -11'sd126 : $signed({3'b000, b[30:23]}) - 11'sd127;
    s1_next.sign    = a[31] ^ b[31];
    s1_next.is_nan  = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
    s1_next.is_inf  = a_inf || b_inf;
    s1_next.is_zero = a_zero || b_zero;
    s1_next.exp     = ea + eb;
    s1_next.prod    = ma * mb;
  end

  always_ff @(posedge clk) begin
    if (en) s1 <= s1_next;
  end

  // stage 2: normalize, round, pack
  logic [5:0]  lz;
  logic [47:0] norm;
  logic signed [11:0] e;     // exponent of the bit at norm[47]
  logic signed [11:0] sh;    // extra right shift for subnormal results
  logic [49:0] wide;         // norm with two guard bits, then shifted
  logic        sticky;
  logic [24:0] rm;
  logic [23:0] mant;
  logic        lsb, grd, rnd;
  logic [8:0]  bexp;
  logic [31:0] res;

  always_comb begin
    lz = 6'd0;
    for (int i = 47; i >= 0; i--) begin
      if (s1.prod[i]) begin
        lz = 6'(47 - i);
        break;
      end
    end
    norm = s1.prod << lz;
    e    = 12'(s1.exp) + 12'sd1 - 12'(lz);
    sh   = (e < -12'sd126) ? (-12'sd126 - e) : 12'sd0;
    if (sh > 12'sd26) sh = 12'sd26;
    // keep 24 bits + guard in wide[49:25]; below is sticky
    wide   = {norm, 2'b00} >> sh[5:0];
    sticky = (wide[23:0] != '0) || (({norm, 2'b00} & ~({50{1'b1}} << sh[5:0])) != '0);
    mant   = wide[49:26];
    grd    = wide[25];
    rnd    = wide[24] | sticky;
    lsb    = mant[0];
    rm     = {1'b0, mant} + 25'((grd && (rnd || lsb)) ? 1 : 0);
    if (sh != 12'sd0) begin
      // subnormal range: exponent field 0 unless rounding reached 1.0
      bexp = rm[23] ? 9'd1 : 9'd0;
      res  = {s1.sign, bexp[7:0], rm[22:0]};
    end else begin
      if (rm[24]) begin
        bexp = 9'(e + 12'sd128);
        res  = {s1.sign, bexp[7:0], rm[23:1]};
      end else begin
        bexp = 9'(e + 12'sd127);
        res  = {s1.sign, bexp[7:0], rm[22:0]};
      end
      if (bexp >= 9'd255) res = {s1.sign, 8'hFF, 23'd0};
    end
    if (s1.is_nan) y = fprs_pkg::CANON_NAN;
    else if (s1.is_inf) y = {s1.sign, 8'hFF, 23'd0};
    else if (s1.is_zero || s1.prod == '0) y = {s1.sign, 31'd0};
    else if (e > 12'sd127) y = {s1.sign, 8'hFF, 23'd0};
    else y = res;
  end

endmodule

### src/fprs_back.sv
// fprs_back: scales a frame's two floats through a two-stage multiplier pair
// and holds results in an output queue. Depends on fprs_pkg, fprs_fmul, fprs_fifo.
module fprs_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             frame_valid,
  input  fprs_pkg::frame_t frame,
  output logic             frame_ready,
  input  logic             pop,
  output logic             empty,
  output logic [7:0]       mode_byte,
  output logic [31:0]      rotate_speed_bits,
  output logic [31:0]      forward_speed_bits
);

  localparam int OUT_DEPTH = 4;

  // stage valids and mode carry
  logic       v1, v2;
  logic [7:0] mode1;
  logic [2:0] inflight;
  logic       q_full;
  fprs_pkg::frame_t res, q_out;

  // reserve queue space for in-flight items so the pipe never stalls
  logic [2:0] q_used;
  assign frame_ready = (q_used + inflight) < 3'(OUT_DEPTH);
  logic take;
  assign take = frame_valid && frame_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) mode1 <= frame.mode;
  end

  assign inflight = 3'(v1) + 3'(v2);

  logic [31:0] r1, r2;
  logic [7:0]  mode2;
  fprs_fmul u_mul_rot (
    .clk(clk), .en(take), .a({~frame.f1[31], frame.f1[30:0]}),
    .b(fprs_pkg::K_THREE), .y(r1)
  );
  fprs_fmul u_mul_fwd (
    .clk(clk), .en(take), .a(frame.f2), .b(fprs_pkg::K_SEVENTENTH), .y(r2)
  );

  // register after multiply before queue
  logic [31:0] r1_q, r2_q;
  always_ff @(posedge clk) begin
    if (v1) begin
      r1_q  <= r1;
      r2_q  <= r2;
      mode2 <= mode1;
    end
  end

  assign res.mode = mode2;
  assign res.f1   = r1_q;
  assign res.f2   = r2_q;

  always_ff @(posedge clk) begin
    if (rst) q_used <= '0;
    else q_used <= q_used + 3'(v2) - 3'(pop && !empty);
  end

  fprs_fifo #(.DEPTH(OUT_DEPTH)) u_outq (
    .clk(clk), .rst(rst), .wr_en(v2), .wr_data(res), .full(q_full),
    .rd_en(pop), .rd_data(q_out), .empty(empty)
  );

  assign mode_byte          = q_out.mode;
  assign rotate_speed_bits  = q_out.f1;
  assign forward_speed_bits = q_out.f2;

endmodule

### src/framed_packet_receiver_scaler_core.sv
// Framed packet receiver/scaler. Takes one serial byte per push, one byte
// per cycle sustained while full is low. A frame is header 0xA5, PAYLOAD_BYTES
// payload bytes, then any bytes until trailer 0x5A; the trailer yields one
// result with the mode byte, -(float1*3.0) and float2*0.7 (IEEE single,
// round to nearest even, canonical NaN). A result passes from the frame
// queue through the multiplier's pipeline register and the result register
// into the output queue. The front framer and back scaler are joined by a
// 4-entry frame queue; full rises only when both queues back up behind a
// stalled pop.
module framed_packet_receiver_scaler_core #(
  parameter int PAYLOAD_BYTES = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  mode_byte,
  output logic [31:0] rotate_speed_bits,
  output logic [31:0] forward_speed_bits
);

  logic             in_valid;
  logic             frame_valid;
  fprs_pkg::frame_t frame, mid_frame;
  logic             mid_full, mid_empty, back_ready;

  assign in_valid = push && !full;
  assign full     = mid_full;

  fprs_front #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_byte(rx_byte),
    .frame_valid(frame_valid), .frame(frame)
  );

  fprs_fifo #(.DEPTH(4)) u_midq (
    .clk(clk), .rst(rst), .wr_en(frame_valid), .wr_data(frame), .full(mid_full),
    .rd_en(back_ready), .rd_data(mid_frame), .empty(mid_empty)
  );

  fprs_back u_back (
    .clk(clk), .rst(rst), .frame_valid(!mid_empty), .frame(mid_frame),
    .frame_ready(back_ready), .pop(pop), .empty(empty), .mode_byte(mode_byte),
    .rotate_speed_bits(rotate_speed_bits), .forward_speed_bits(forward_speed_bits)
  );

endmodule

### src/fprs_checker.sv
// fprs_checker: port-level checks for the receiver/scaler core.
// Depends on framed_packet_receiver_scaler_core ports only.
module fprs_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        pop,
  input logic        empty,
  input logic [7:0]  mode_byte,
  input logic [31:0] rotate_speed_bits,
  input logic [31:0] forward_speed_bits
);

  // a waiting result holds while it is not taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(mode_byte) && $stable(rotate_speed_bits)
                          && $stable(forward_speed_bits)))
    else $error("result changed while waiting");

  // nothing is waiting just after reset
  a_rst_empty: assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("result present after reset");

  // NaN results on rotate_speed_bits are always canonical
  a_nan: assert property (@(posedge clk) disable iff (rst)
    (!empty && rotate_speed_bits[30:23] == 8'hFF && rotate_speed_bits[22:0] != 23'd0)
      |-> rotate_speed_bits == 32'h7FC0_0000)
    else $error("non-canonical NaN");

  // no result appears without pushes in the cycles before
  a_no_spont: assert property (@(posedge clk) disable iff (rst)
    (empty && $past(empty) && !$past(push) && !$past(push, 2) && !$past(push, 3))
      |=> empty)
    else $error("result without input");

endmodule

bind framed_packet_receiver_scaler_core fprs_checker u_fprs_checker (
  .clk(clk), .rst(rst), .push(push), .full(full), .pop(pop), .empty(empty),
  .mode_byte(mode_byte), .rotate_speed_bits(rotate_speed_bits),
  .forward_speed_bits(forward_speed_bits)
);
